// ===== rtl/pvsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvsa_pkg: shared types for the priority voice slot allocator
// Beat payloads, outcome codes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pvsa_pkg;

   localparam int NUM_SLOTS_DEF = 3;
   localparam int SLOT_W        = 2;
   localparam int ID_W          = 8;
   localparam int AGE_W         = 8;
   localparam int PRIO_W        = 4;

   typedef enum logic [2:0] {
      OUT_RESTARTED  = 3'd0,
      OUT_LOOP_ARMED = 3'd1,
      OUT_FREE_SLOT  = 3'd2,
      OUT_STOLEN     = 3'd3,
      OUT_REJECTED   = 3'd4,
      OUT_IGNORED    = 3'd5,
      OUT_TICK       = 3'd6
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              action;
      logic [ID_W-1:0]   sound_id;
      logic [PRIO_W-1:0] priority_req;
      logic [AGE_W-1:0]  length;
      logic              looping;
   } req_type;

   typedef struct packed {
      outcome_type       outcome;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   slot_sound;
      logic [AGE_W-1:0]  age;
      logic              playing;
      logic              ends_now;
      logic [ID_W-1:0]   current_sound;
      logic              last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic start;
      logic scan;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic idx_last;
      logic is_tick;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/pvsa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvsa_if: valid/ready channels of the voice slot allocator
// One interface for request beats and one for result beats.
// ----------------------------------------------------------------------------
interface pvsa_req_if
   import pvsa_pkg::*;
   ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pvsa_rsp_if
   import pvsa_pkg::*;
   ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/pvsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvsa_ctrl: sequencing controller
// Accepts one beat, steps the datapath over the slots, then issues the
// result beats as the output register frees up.
// ----------------------------------------------------------------------------
module pvsa_ctrl
   import pvsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.idx_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free && (!status.is_tick || status.idx_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/pvsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvsa_dp: slot state, one-slot-per-cycle scan unit and result register
// Scans one slot per cycle to find a match or victim (request) or to age
// the slot and record its report (tick), then builds each result beat.
// ----------------------------------------------------------------------------
module pvsa_dp
   import pvsa_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
)(
   input  logic           clock,
   input  logic           reset,
   input  cmd_type        cmd,
   input  req_type        req_data,
   output status_type     status,
   pvsa_rsp_if.source     rsp_ch
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

   // slot state
   logic [ID_W-1:0]   id_ff   [NUM_SLOTS];
   logic [AGE_W-1:0]  age_ff  [NUM_SLOTS];
   logic [AGE_W-1:0]  len_ff  [NUM_SLOTS];
   logic [PRIO_W-1:0] prio_ff [NUM_SLOTS];
   logic              rt_ff   [NUM_SLOTS];
   logic [ID_W-1:0]   cur_ff;
   logic [ID_W-1:0]   id_in   [NUM_SLOTS];
   logic [AGE_W-1:0]  age_in  [NUM_SLOTS];
   logic [AGE_W-1:0]  len_in  [NUM_SLOTS];
   logic [PRIO_W-1:0] prio_in [NUM_SLOTS];
   logic              rt_in   [NUM_SLOTS];
   logic [ID_W-1:0]   cur_in;

   // item and scan accumulators
   req_type           rq_ff, rq_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              match_ff, match_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic [AGE_W-1:0]  match_age_ff, match_age_in;
   logic              free_ff, free_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  vic_idx_ff, vic_idx_in;
   logic [PRIO_W-1:0] vic_prio_ff, vic_prio_in;
   logic [AGE_W-1:0]  vic_age_ff, vic_age_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [ID_W-1:0]   top_id_ff, top_id_in;
   logic [ID_W-1:0]   rep_id_ff  [NUM_SLOTS];
   logic [AGE_W-1:0]  rep_age_ff [NUM_SLOTS];
   logic              rep_end_ff [NUM_SLOTS];
   logic [ID_W-1:0]   rep_id_in  [NUM_SLOTS];
   logic [AGE_W-1:0]  rep_age_in [NUM_SLOTS];
   logic              rep_end_in [NUM_SLOTS];

   // result register
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   rsp_type           beat;

   // slot under scan
   logic [ID_W-1:0]   s_id;
   logic [AGE_W-1:0]  s_age, s_len, s_age_inc;
   logic [PRIO_W-1:0] s_prio;
   logic              s_rt, s_busy, s_hit, s_ends, s_top;
   logic              is_tick, idx_last;

   // request decision
   logic              rq_ignore, rq_take;

   assign is_tick  = rq_ff.action;
   assign idx_last = (idx_ff == IDX_LAST);

   assign s_id      = id_ff[idx_ff];
   assign s_age     = age_ff[idx_ff];
   assign s_len     = len_ff[idx_ff];
   assign s_prio    = prio_ff[idx_ff];
   assign s_rt      = rt_ff[idx_ff];
   assign s_busy    = (s_id != '0);
   assign s_age_inc = s_age + 8'd1;
   assign s_hit     = (s_age_inc >= s_len);
   assign s_ends    = s_busy && s_hit && !s_rt;
   assign s_top     = s_busy && !s_ends && (s_prio >= best_prio_ff);

   assign rq_ignore = (rq_ff.sound_id == '0);
   assign rq_take   = !rq_ignore && !match_ff &&
                      (free_ff || (rq_ff.priority_req >= vic_prio_ff));

   assign status.idx_last = idx_last;
   assign status.is_tick  = is_tick;
   assign status.out_free = !out_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_ff;

   // build the result beat
   always_comb begin
      beat = '0;
      if (is_tick) begin
         beat.outcome       = OUT_TICK;
         beat.slot          = SLOT_W'(idx_ff);
         beat.slot_sound    = rep_id_ff[idx_ff];
         beat.age           = rep_age_ff[idx_ff];
         beat.playing       = (rep_id_ff[idx_ff] != '0);
         beat.ends_now      = rep_end_ff[idx_ff];
         beat.current_sound = cur_ff;
         beat.last          = idx_last;
      end else begin
         beat.last          = 1'b1;
         beat.current_sound = cur_ff;
         if (rq_ignore) begin
            beat.outcome = OUT_IGNORED;
         end else if (match_ff) begin
            beat.outcome       = rq_ff.looping ? OUT_LOOP_ARMED : OUT_RESTARTED;
            beat.slot          = SLOT_W'(match_idx_ff);
            beat.slot_sound    = rq_ff.sound_id;
            beat.age           = rq_ff.looping ? match_age_ff : '0;
            beat.playing       = 1'b1;
            beat.current_sound = rq_ff.sound_id;
         end else if (rq_take) begin
            beat.outcome       = free_ff ? OUT_FREE_SLOT : OUT_STOLEN;
            beat.slot          = SLOT_W'(vic_idx_ff);
            beat.slot_sound    = rq_ff.sound_id;
            beat.playing       = 1'b1;
            beat.current_sound = rq_ff.sound_id;
         end else begin
            beat.outcome = OUT_REJECTED;
         end
      end
   end

   // slot state update: age on tick scan, restart/arm or allocate on request emit
   always_comb begin
      id_in   = id_ff;
      age_in  = age_ff;
      len_in  = len_ff;
      prio_in = prio_ff;
      rt_in   = rt_ff;
      cur_in  = cur_ff;
      if (cmd.scan && is_tick) begin
         if (s_busy) begin
            age_in[idx_ff] = s_age_inc;
            if (s_hit) begin
               if (s_rt) begin
                  age_in[idx_ff] = '0;
                  rt_in[idx_ff]  = 1'b0;
               end else begin
                  id_in[idx_ff] = '0;
               end
            end
         end
         if (idx_last) cur_in = s_top ? s_id : top_id_ff;
      end
      if (cmd.emit && !is_tick && !rq_ignore) begin
         if (match_ff) begin
            if (rq_ff.looping) rt_in[match_idx_ff] = 1'b1;
            else               age_in[match_idx_ff] = '0;
            cur_in = rq_ff.sound_id;
         end else if (rq_take) begin
            id_in[vic_idx_ff]   = rq_ff.sound_id;
            age_in[vic_idx_ff]  = '0;
            len_in[vic_idx_ff]  = rq_ff.length;
            prio_in[vic_idx_ff] = rq_ff.priority_req;
            rt_in[vic_idx_ff]   = 1'b0;
            cur_in              = rq_ff.sound_id;
         end
      end
   end

   // scan accumulators, reports and slot index
   always_comb begin
      rq_in        = rq_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      match_age_in = match_age_ff;
      free_in      = free_ff;
      found_in     = found_ff;
      vic_idx_in   = vic_idx_ff;
      vic_prio_in  = vic_prio_ff;
      vic_age_in   = vic_age_ff;
      best_prio_in = best_prio_ff;
      top_id_in    = top_id_ff;
      rep_id_in    = rep_id_ff;
      rep_age_in   = rep_age_ff;
      rep_end_in   = rep_end_ff;
      if (cmd.start) begin
         rq_in        = req_data;
         idx_in       = '0;
         match_in     = 1'b0;
         free_in      = 1'b0;
         found_in     = 1'b0;
         best_prio_in = '0;
         top_id_in    = '0;
      end
      if (cmd.scan) begin
         idx_in = idx_last ? '0 : idx_ff + 1'b1;
         // first slot already playing this id
         if (!match_ff && s_busy && (s_id == rq_ff.sound_id)) begin
            match_in     = 1'b1;
            match_idx_in = idx_ff;
            match_age_in = s_age;
         end
         // first free slot, else lowest priority, older first
         if (!free_ff) begin
            if (!s_busy) begin
               free_in    = 1'b1;
               vic_idx_in = idx_ff;
            end else if (!found_ff || (s_prio < vic_prio_ff) ||
                         ((s_prio == vic_prio_ff) && (s_age > vic_age_ff))) begin
               found_in    = 1'b1;
               vic_idx_in  = idx_ff;
               vic_prio_in = s_prio;
               vic_age_in  = s_age;
            end
         end
         // tick report and survivor tracking
         rep_id_in[idx_ff]  = s_id;
         rep_age_in[idx_ff] = s_busy ? s_age : '0;
         rep_end_in[idx_ff] = s_ends;
         if (s_top) begin
            best_prio_in = s_prio;
            top_id_in    = s_id;
         end
      end
      if (cmd.emit && is_tick) begin
         idx_in = idx_last ? '0 : idx_ff + 1'b1;
      end
   end

   // result register: load on emit, drop when taken
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_ch.ready) out_valid_in = 1'b0;
      if (cmd.emit) begin
         out_in       = beat;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            id_ff[i]   <= '0;
            age_ff[i]  <= '0;
            len_ff[i]  <= '0;
            prio_ff[i] <= '0;
            rt_ff[i]   <= 1'b0;
         end
         cur_ff       <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         id_ff        <= id_in;
         age_ff       <= age_in;
         len_ff       <= len_in;
         prio_ff      <= prio_in;
         rt_ff        <= rt_in;
         cur_ff       <= cur_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_ff        <= rq_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      match_age_ff <= match_age_in;
      free_ff      <= free_in;
      found_ff     <= found_in;
      vic_idx_ff   <= vic_idx_in;
      vic_prio_ff  <= vic_prio_in;
      vic_age_ff   <= vic_age_in;
      best_prio_ff <= best_prio_in;
      top_id_ff    <= top_id_in;
      rep_id_ff    <= rep_id_in;
      rep_age_ff   <= rep_age_in;
      rep_end_ff   <= rep_end_in;
      out_ff       <= out_in;
   end

endmodule

// ===== rtl/priority_voice_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_voice_slot_allocator: voice slot allocation with priority stealing
// Tracks NUM_SLOTS playing sounds, places requests into free or stolen
// slots, and ages every slot on each frame tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one beat per request (action 0) or frame tick (action 1).
//   rsp_ch returns one beat per request and NUM_SLOTS beats per tick, the
//   final beat of each input flagged by last.
//   An accepted beat is followed by a scan of all NUM_SLOTS slots, one
//   slot per cycle through the shared compare/age unit, then by its
//   result beats. One input is handled at a time.
//   The result register lets the next input enter and scan while the last
//   beat of the previous one still waits on rsp_ch.
//   When rsp_ch stalls, the beat holds in the result register and the
//   controller waits before loading the next one; nothing is dropped.
//   Reset empties all slots and clears the current sound; the block is
//   ready for a beat in the first cycle after reset.
// ----------------------------------------------------------------------------
module priority_voice_slot_allocator
   import pvsa_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
)(
   input  logic       clock,
   input  logic       reset,
   pvsa_req_if.sink   req_ch,
   pvsa_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_ch.ready = req_ready;

   // sequencing
   pvsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // slot state and scan
   pvsa_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_ch.payload),
      .status   (status),
      .rsp_ch   (rsp_ch)
   );

endmodule
